// ===== sv/wvs_pkg.sv =====
// ----------------------------------------------------------------------------
// wvs_pkg
// Shared types and constants of the vertex skinning unit: field widths,
// matrix shape, the command code and the queue entry between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

package wvs_pkg;

	// joint storage
	localparam int JOINT_COUNT_DEF = 128;
	localparam int ROWS            = 3;
	localparam int COLS            = 4;
	localparam int WORDS_PER_JOINT = ROWS * COLS;

	// field widths
	localparam int VAL_W   = 32;
	localparam int JOINT_W = 7;
	localparam int WIDX_W  = 4;

	// arithmetic widths
	localparam int MUL_W  = 2 * VAL_W;     // exact Q32.32 product
	localparam int FRAC_W = 16;            // fraction bits dropped after a product
	localparam int PROD_W = MUL_W - FRAC_W; // product floored to Q32.16
	localparam int ROW_W  = PROD_W + 2;    // four products added exactly
	localparam int SUM_W  = 48;            // running sum
	localparam int ACC_W  = ROW_W + 1;     // running sum plus one row term

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// input kind codes
	localparam logic KIND_LOAD   = 1'b0;
	localparam logic KIND_WEIGHT = 1'b1;

	// command carried through the queue
	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,  // write one matrix word
		OP_WEIGHT = 2'd1,  // add a contribution into the sums
		OP_FLUSH  = 2'd2   // emit and clear without adding
	} wvs_op_t;

	typedef struct packed {
		wvs_op_t                  op;
		logic [JOINT_W-1:0]       joint;
		logic [WIDX_W-1:0]        word_index;
		logic signed [VAL_W-1:0]  word_value;
		logic signed [VAL_W-1:0]  vec_x;
		logic signed [VAL_W-1:0]  vec_y;
		logic signed [VAL_W-1:0]  vec_z;
		logic signed [VAL_W-1:0]  vec_w;
		logic                     last;
	} wvs_entry_t;

	// write side of the queue
	typedef struct packed {
		logic       push;
		wvs_entry_t entry;
	} wvs_wr_t;

	// read side of the queue
	typedef struct packed {
		logic       empty;
		wvs_entry_t entry;
	} wvs_head_t;

endpackage

`default_nettype wire

// ===== sv/wvs_in_if.sv =====
// ----------------------------------------------------------------------------
// wvs_in_if
// Input channel of the skinning unit: load words and weight contributions.
// ----------------------------------------------------------------------------
`default_nettype none

interface wvs_in_if import wvs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    kind;
	logic [JOINT_W-1:0]      joint_number;
	logic [WIDX_W-1:0]       word_index;
	logic signed [VAL_W-1:0] word_value;
	logic signed [VAL_W-1:0] weight_x;
	logic signed [VAL_W-1:0] weight_y;
	logic signed [VAL_W-1:0] weight_z;
	logic signed [VAL_W-1:0] weight_w;
	logic                    last_weight;

	modport source (
		output valid, kind, joint_number, word_index, word_value,
		output weight_x, weight_y, weight_z, weight_w, last_weight,
		input  ready
	);

	modport sink (
		input  valid, kind, joint_number, word_index, word_value,
		input  weight_x, weight_y, weight_z, weight_w, last_weight,
		output ready
	);
endinterface

`default_nettype wire

// ===== sv/wvs_out_if.sv =====
// ----------------------------------------------------------------------------
// wvs_out_if
// Output channel of the skinning unit: one skinned position per vertex.
// ----------------------------------------------------------------------------
`default_nettype none

interface wvs_out_if import wvs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] pos_x;
	logic signed [VAL_W-1:0] pos_y;
	logic signed [VAL_W-1:0] pos_z;

	modport source (
		output valid, pos_x, pos_y, pos_z,
		input  ready
	);

	modport sink (
		input  valid, pos_x, pos_y, pos_z,
		output ready
	);
endinterface

`default_nettype wire

// ===== sv/weighted_vertex_skinning_unit.sv =====
// A weight word that ends a vertex passes from acceptance through the
// queue, matrix bank read, multipliers, row adders, then the result register.
// Throughput is one word per cycle while no result waits, set by the twelve parallel 32x32 multipliers.
// The result register stalls the pipeline only while a result waits to be taken.
// Reset clears the queue, pipeline valids and running sums; the matrix store keeps
// no reset value and must be loaded before a joint is used.
// ----------------------------------------------------------------------------
// weighted_vertex_skinning_unit
// Linear blend skinning in Q16.16: per-joint 3x4 matrices, weighted
// contributions summed into saturating 48-bit sums, one position per vertex.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_vertex_skinning_unit import wvs_pkg::*; #(
	parameter int JOINT_COUNT = JOINT_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	wvs_in_if.sink    item,
	wvs_out_if.source result
);

	wvs_wr_t   q_wr;
	wvs_head_t q_head;
	logic      q_full;
	logic      q_pop;

	// accept and classify
	wvs_front #(
		.JOINT_COUNT (JOINT_COUNT)
	) u_front (
		.item   (item),
		.q_full (q_full),
		.q_wr   (q_wr)
	);

	// decoupling queue
	wvs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.pop    (q_pop),
		.full   (q_full),
		.head   (q_head)
	);

	// execute
	wvs_back #(
		.JOINT_COUNT (JOINT_COUNT)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.pop    (q_pop),
		.result (result)
	);

endmodule

`default_nettype wire

// ===== sv/wvs_front.sv =====
// ----------------------------------------------------------------------------
// wvs_front
// Accepts input words, checks joint and word ranges and turns each word into
// a queue command; words that can have no effect are taken and dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module wvs_front import wvs_pkg::*; #(
	parameter int JOINT_COUNT = JOINT_COUNT_DEF
) (
	wvs_in_if.sink    item,
	input  logic      q_full,
	output wvs_wr_t   q_wr
);

	logic joint_ok;
	logic word_ok;
	logic keep;

	// range checks
	assign joint_ok = int'(item.joint_number) < JOINT_COUNT;
	assign word_ok  = item.word_index < WIDX_W'(WORDS_PER_JOINT);

	// accept whenever the queue has room
	assign item.ready = !q_full;

	// classify the word
	always_comb begin
		q_wr.entry.joint      = item.joint_number;
		q_wr.entry.word_index = item.word_index;
		q_wr.entry.word_value = item.word_value;
		q_wr.entry.vec_x      = item.weight_x;
		q_wr.entry.vec_y      = item.weight_y;
		q_wr.entry.vec_z      = item.weight_z;
		q_wr.entry.vec_w      = item.weight_w;
		q_wr.entry.last       = item.last_weight;
		unique case (item.kind)
			KIND_LOAD: begin
				q_wr.entry.op = OP_LOAD;
				keep          = joint_ok && word_ok;
			end
			KIND_WEIGHT: begin
				q_wr.entry.op = joint_ok ? OP_WEIGHT : OP_FLUSH;
				keep          = joint_ok || item.last_weight;
			end
			default: begin
				q_wr.entry.op = OP_LOAD;
				keep          = 1'b0;
			end
		endcase
		q_wr.push = item.valid && item.ready && keep;
	end

endmodule

`default_nettype wire

// ===== sv/wvs_queue.sv =====
// ----------------------------------------------------------------------------
// wvs_queue
// Short first-in first-out queue of commands between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module wvs_queue import wvs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  wvs_wr_t   wr,
	input  logic      pop,
	output logic      full,
	output wvs_head_t head
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	wvs_entry_t      slot_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_pop;

	assign full       = count_q == CW'(QUEUE_DEPTH);
	assign head.empty = count_q == '0;
	assign head.entry = slot_q[rd_ptr_q];
	assign do_pop     = pop && !head.empty;

	// storage
	always_ff @(posedge clk) begin
		if (wr.push) begin
			slot_q[wr_ptr_q] <= wr.entry;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({wr.push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue fill count beyond depth");
`endif

endmodule

`default_nettype wire

// ===== sv/wvs_back.sv =====
// ----------------------------------------------------------------------------
// wvs_back
// Carries out queue commands: matrix word store in twelve banks, twelve
// multipliers, row adders, saturating running sums and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wvs_back import wvs_pkg::*; #(
	parameter int JOINT_COUNT = JOINT_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  wvs_head_t  head,
	output logic       pop,
	wvs_out_if.source  result
);

	localparam int JW = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
	localparam int XW = (JW > JOINT_W) ? JW : JOINT_W;

	logic                     adv;
	logic [XW-1:0]            joint_ext;
	logic [JW-1:0]            addr;
	logic                     mem_we;
	logic                     mem_re;
	logic signed [VAL_W-1:0]  mword [WORDS_PER_JOINT];

	// stage 1: matrix read
	logic                     valid_s1;
	logic                     use_s1;
	logic                     last_s1;
	logic signed [VAL_W-1:0]  vec_s1 [COLS];

	// stage 2: products
	logic                     valid_s2;
	logic                     use_s2;
	logic                     last_s2;
	logic signed [MUL_W-1:0]  full_prod [ROWS][COLS];
	logic signed [PROD_W-1:0] prod_s2 [ROWS][COLS];

	// stage 3: row terms
	logic                     valid_s3;
	logic                     last_s3;
	logic signed [ROW_W-1:0]  row_s3 [ROWS];

	// running sums and result
	logic signed [SUM_W-1:0]  sum_q [ROWS];
	logic signed [ACC_W-1:0]  acc [ROWS];
	logic                     out_valid_q;
	logic signed [VAL_W-1:0]  pos_q [ROWS];

	// clamp to the running sum range
	function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [ACC_W-1:0] v);
		logic signed [SUM_W-1:0] r;
		if (&v[ACC_W-1:SUM_W-1] || ~|v[ACC_W-1:SUM_W-1]) begin
			r = v[SUM_W-1:0];
		end else if (v[ACC_W-1]) begin
			r = {1'b1, {(SUM_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(SUM_W-1){1'b1}}};
		end
		return r;
	endfunction

	// clamp to the output range
	function automatic logic signed [VAL_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
		logic signed [VAL_W-1:0] r;
		if (&v[ACC_W-1:VAL_W-1] || ~|v[ACC_W-1:VAL_W-1]) begin
			r = v[VAL_W-1:0];
		end else if (v[ACC_W-1]) begin
			r = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(VAL_W-1){1'b1}}};
		end
		return r;
	endfunction

	// whole pipeline moves unless a result waits
	assign adv       = !out_valid_q || result.ready;
	assign pop       = adv && !head.empty;
	assign joint_ext = XW'(head.entry.joint);
	assign addr      = joint_ext[JW-1:0];
	assign mem_we    = pop && (head.entry.op == OP_LOAD);
	assign mem_re    = pop && (head.entry.op != OP_LOAD);

	// one bank per matrix word, all read at the same joint
	for (genvar w = 0; w < WORDS_PER_JOINT; w++) begin : g_bank
		logic signed [VAL_W-1:0] mem [JOINT_COUNT];
		logic signed [VAL_W-1:0] rd_s1;

		always_ff @(posedge clk) begin
			if (mem_we && head.entry.word_index == WIDX_W'(w)) begin
				mem[addr] <= head.entry.word_value;
			end
			if (mem_re) begin
				rd_s1 <= mem[addr];
			end
		end

		assign mword[w] = rd_s1;
	end

	// stage 1 control and vector
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= mem_re;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			use_s1    <= head.entry.op == OP_WEIGHT;
			last_s1   <= head.entry.last;
			vec_s1[0] <= head.entry.vec_x;
			vec_s1[1] <= head.entry.vec_y;
			vec_s1[2] <= head.entry.vec_z;
			vec_s1[3] <= head.entry.vec_w;
		end
	end

	// twelve multipliers
	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			for (int c = 0; c < COLS; c++) begin
				full_prod[r][c] = MUL_W'(mword[r*COLS+c]) * MUL_W'(vec_s1[c]);
			end
		end
	end

	// stage 2: products floored to Q32.16
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			use_s2  <= use_s1;
			last_s2 <= last_s1;
			for (int r = 0; r < ROWS; r++) begin
				for (int c = 0; c < COLS; c++) begin
					prod_s2[r][c] <= full_prod[r][c][MUL_W-1:FRAC_W];
				end
			end
		end
	end

	// stage 3: row dot products, zero for a joint out of range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			last_s3 <= last_s2;
			for (int r = 0; r < ROWS; r++) begin
				row_s3[r] <= use_s2 ? (ROW_W'(prod_s2[r][0]) + ROW_W'(prod_s2[r][1])
					+ ROW_W'(prod_s2[r][2]) + ROW_W'(prod_s2[r][3])) : '0;
			end
		end
	end

	// running sum plus this row term
	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			acc[r] = ACC_W'(sum_q[r]) + ACC_W'(row_s3[r]);
		end
	end

	// accumulate, emit and clear on the last word of a vertex
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) begin
				sum_q[r] <= '0;
			end
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s3 && last_s3;
			if (valid_s3) begin
				for (int r = 0; r < ROWS; r++) begin
					sum_q[r] <= last_s3 ? '0 : sat_sum(acc[r]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s3 && last_s3) begin
			for (int r = 0; r < ROWS; r++) begin
				pos_q[r] <= sat_out(acc[r]);
			end
		end
	end

	assign result.valid = out_valid_q;
	assign result.pos_x = pos_q[0];
	assign result.pos_y = pos_q[1];
	assign result.pos_z = pos_q[2];

`ifndef SYNTHESIS
	a_emit: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s3 && last_s3 |=> out_valid_q)
		else $error("last word of a vertex did not produce a result");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv && valid_s3 && last_s3 |=> sum_q[0] == '0 && sum_q[1] == '0 && sum_q[2] == '0)
		else $error("running sums not cleared after a result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(valid_s3) && $stable(valid_s2) && $stable(valid_s1))
		else $error("pipeline moved while a result was held");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vertex skinning unit. Matrix words are loaded
// into joints, then weighted contributions stream in and every vertex end is
// predicted in Q16.16 with floored products, saturating 48-bit sums and
// saturated 32-bit outputs. Both channels idle at random, with a steady
// stretch in the middle of the run.
// ----------------------------------------------------------------------------
module tb_top;
	import wvs_pkg::*;

	localparam int          RANDOM_WORDS = 1300;
	localparam int          DRAIN_CYCLES = 20;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam longint      SUM_HI       = (longint'(1) <<< (SUM_W - 1)) - 1;
	localparam longint      SUM_LO       = -SUM_HI - 1;
	localparam longint      POS_HI       = 64'sd2147483647;
	localparam longint      POS_LO       = -POS_HI - 1;

	typedef struct {
		logic                    kind;
		logic [JOINT_W-1:0]      joint;
		logic [WIDX_W-1:0]       widx;
		logic signed [VAL_W-1:0] wval;
		logic signed [VAL_W-1:0] vec [COLS];
		logic                    last;
	} skin_word_t;

	// x in slot 0, y in slot 1, z in slot 2
	typedef logic [ROWS-1:0][VAL_W-1:0] skin_pos_t;

	// predicted matrices and sums, positions still owed by the block
	class vertex_scoreboard;
		logic signed [VAL_W-1:0] matrix [JOINT_COUNT_DEF*WORDS_PER_JOINT];
		longint                  sums [ROWS];
		skin_pos_t               pending [$];
		int unsigned             mismatches;

		function new();
			foreach (matrix[i]) matrix[i] = '0;
			foreach (sums[r]) sums[r] = 0;
			mismatches = 0;
		endfunction

		// update the joint store or the sums for one accepted word
		function void apply_word(skin_word_t w);
			longint    row;
			longint    raw;
			int        base;
			skin_pos_t p;
			if (w.kind == KIND_LOAD) begin
				if (w.widx < WORDS_PER_JOINT)
					matrix[int'(w.joint) * WORDS_PER_JOINT + int'(w.widx)] = w.wval;
				return;
			end
			base = int'(w.joint) * WORDS_PER_JOINT;
			if (int'(w.joint) < JOINT_COUNT_DEF) begin
				for (int r = 0; r < ROWS; r++) begin
					row = 0;
					// each product floored to Q32.16
					for (int c = 0; c < COLS; c++)
						row += (longint'(matrix[base + r*COLS + c]) * longint'(w.vec[c]))
							>>> FRAC_W;
					raw = sums[r] + row;
					sums[r] = (raw > SUM_HI) ? SUM_HI : (raw < SUM_LO) ? SUM_LO : raw;
				end
			end
			if (!w.last)
				return;
			// vertex end: clamp to 32 bits and clear
			for (int r = 0; r < ROWS; r++) begin
				if (sums[r] > POS_HI)
					p[r] = POS_HI[VAL_W-1:0];
				else if (sums[r] < POS_LO)
					p[r] = POS_LO[VAL_W-1:0];
				else
					p[r] = sums[r][VAL_W-1:0];
				sums[r] = 0;
			end
			pending.push_back(p);
		endfunction

		// compare one delivered position with the oldest prediction
		function void check_position(skin_pos_t got);
			skin_pos_t want;
			string     axis_name [ROWS];
			axis_name = '{"pos_x", "pos_y", "pos_z"};
			if (pending.size() == 0) begin
				$display("%0t: unexpected position, actual %0d %0d %0d", $time,
					$signed(got[0]), $signed(got[1]), $signed(got[2]));
				mismatches++;
				return;
			end
			want = pending.pop_front();
			for (int r = 0; r < ROWS; r++) begin
				if (got[r] !== want[r]) begin
					$display("%0t: %s mismatch, expected %0d, actual %0d", $time,
						axis_name[r], $signed(want[r]), $signed(got[r]));
					mismatches++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	wvs_in_if  item_ch ();
	wvs_out_if pos_ch ();

	weighted_vertex_skinning_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (pos_ch)
	);

	vertex_scoreboard vertex_sb = new();

	// stimulus bookkeeping: which matrix words hold a value
	bit [WORDS_PER_JOINT-1:0] written [JOINT_COUNT_DEF];
	bit                       loaded [JOINT_COUNT_DEF];
	int                       usable [$];
	int unsigned              words_sent;
	int unsigned              cycle_count;
	bit                       steady;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		pos_ch.ready <= steady || ($urandom_range(99) >= 16);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && pos_ch.valid && pos_ch.ready)
			vertex_sb.check_position({pos_ch.pos_z, pos_ch.pos_y, pos_ch.pos_x});
	end

	// value mix: extremes, near zero, around unity, anything
	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return {1'b0, {(VAL_W-1){1'b1}}};
			1: return {1'b1, {(VAL_W-1){1'b0}}};
			2: return $signed($urandom_range(6)) - 3;
			3, 4, 5: return $signed($urandom_range(1 << 21)) - (1 << 20);
			default: return $urandom;
		endcase
	endfunction

	// word with every field random, ignored ones included
	function automatic skin_word_t blank_word(logic kind);
		skin_word_t w;
		w.kind  = kind;
		w.joint = JOINT_W'($urandom);
		w.widx  = WIDX_W'($urandom);
		w.wval  = $urandom;
		foreach (w.vec[c]) w.vec[c] = $urandom;
		w.last  = 1'($urandom);
		return w;
	endfunction

	// drive one word, wait for it to be taken, then predict
	task automatic send_word(input skin_word_t w);
		while (!steady && $urandom_range(99) < 16) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.kind         <= w.kind;
		item_ch.joint_number <= w.joint;
		item_ch.word_index   <= w.widx;
		item_ch.word_value   <= w.wval;
		item_ch.weight_x     <= w.vec[0];
		item_ch.weight_y     <= w.vec[1];
		item_ch.weight_z     <= w.vec[2];
		item_ch.weight_w     <= w.vec[3];
		item_ch.last_weight  <= w.last;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		vertex_sb.apply_word(w);
		words_sent++;
		steady = (words_sent >= 500 && words_sent < 800);
		// a joint may be used once all its words are written
		if (w.kind == KIND_LOAD && w.widx < WORDS_PER_JOINT) begin
			written[w.joint][w.widx] = 1'b1;
			if (!loaded[w.joint] && (&written[w.joint])) begin
				loaded[w.joint] = 1'b1;
				usable.push_back(int'(w.joint));
			end
		end
	endtask

	task automatic send_weight(input int joint, input logic signed [VAL_W-1:0] x,
		input logic signed [VAL_W-1:0] y, input logic signed [VAL_W-1:0] z,
		input logic signed [VAL_W-1:0] wt, input logic last);
		skin_word_t w;
		w        = blank_word(KIND_WEIGHT);
		w.joint  = JOINT_W'(joint);
		w.vec[0] = x;
		w.vec[1] = y;
		w.vec[2] = z;
		w.vec[3] = wt;
		w.last   = last;
		send_word(w);
	endtask

	// main sequence
	initial begin
		skin_word_t              w;
		int                      j;
		int unsigned             target;
		logic signed [VAL_W-1:0] big;
		logic signed [VAL_W-1:0] least;
		big   = {1'b0, {(VAL_W-1){1'b1}}};
		least = {1'b1, {(VAL_W-1){1'b0}}};

		// known levels from the start
		arst_n               = 1'b0;
		item_ch.valid        = 1'b0;
		item_ch.kind         = KIND_LOAD;
		item_ch.joint_number = '0;
		item_ch.word_index   = '0;
		item_ch.word_value   = '0;
		item_ch.weight_x     = '0;
		item_ch.weight_y     = '0;
		item_ch.weight_z     = '0;
		item_ch.weight_w     = '0;
		item_ch.last_weight  = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// top joint: row of maxima, row of minima, mixed row
		for (int k = 0; k < WORDS_PER_JOINT; k++) begin
			w       = blank_word(KIND_LOAD);
			w.joint = JOINT_W'(JOINT_COUNT_DEF - 1);
			w.widx  = WIDX_W'(k);
			case (k)
				0, 1, 2, 3, 8: w.wval = big;
				4, 5, 6, 7, 9: w.wval = least;
				10:            w.wval = 1;
				default:       w.wval = -1;
			endcase
			send_word(w);
		end

		// loads past the last matrix word are dropped
		w       = blank_word(KIND_LOAD);
		w.joint = JOINT_W'(JOINT_COUNT_DEF - 1);
		w.widx  = WIDX_W'(WORDS_PER_JOINT);
		send_word(w);
		w.widx  = '1;
		w.wval  = 0;
		send_word(w);

		// sums pushed into both 48-bit limits, then the 32-bit clamp
		send_weight(JOINT_COUNT_DEF - 1, big, big, big, big, 1'b0);
		send_weight(JOINT_COUNT_DEF - 1, big, big, big, big, 1'b1);
		send_weight(JOINT_COUNT_DEF - 1, least, least, least, least, 1'b1);
		// flooring of tiny negative products
		send_weight(JOINT_COUNT_DEF - 1, -1, -1, -1, -1, 1'b1);
		send_weight(JOINT_COUNT_DEF - 1, 0, 0, 0, 0, 1'b1);
		// two contributions into one vertex
		send_weight(JOINT_COUNT_DEF - 1, 32'sh0001_0000, 0, 0, 0, 1'b0);
		send_weight(JOINT_COUNT_DEF - 1, 0, 0, -1, 32'sh0001_0000, 1'b1);

		// random traffic: mostly weights over loaded joints, some reloads
		target = words_sent + RANDOM_WORDS;
		while (words_sent < target) begin
			j = $urandom_range(99);
			if (j < 4 || usable.size() < 4) begin
				// whole joint in one go
				j = $urandom_range(JOINT_COUNT_DEF - 1);
				for (int k = 0; k < WORDS_PER_JOINT; k++) begin
					w       = blank_word(KIND_LOAD);
					w.joint = JOINT_W'(j);
					w.widx  = WIDX_W'(k);
					w.wval  = pick_value();
					send_word(w);
				end
			end else if (j < 14) begin
				// single word, any joint, any index
				w      = blank_word(KIND_LOAD);
				w.wval = pick_value();
				send_word(w);
			end else begin
				send_weight(usable[$urandom_range(usable.size() - 1)], pick_value(),
					pick_value(), pick_value(), pick_value(), $urandom_range(99) < 30);
			end
		end
		item_ch.valid <= 1'b0;

		// drain
		while (vertex_sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (vertex_sb.mismatches == 0 && vertex_sb.pending.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/wvs_pkg.sv
sv/wvs_in_if.sv
sv/wvs_out_if.sv
sv/wvs_front.sv
sv/wvs_queue.sv
sv/wvs_back.sv
sv/weighted_vertex_skinning_unit.sv
verif/tb_top.sv
